// ----- rtl/sadk_pkg.sv -----
// Shared types and constants for the session attach/detach/keepalive controller.
// Holds the command, state and message codes, the register map and the beat structs.
// No dependencies.
`default_nettype none

package sadk_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_ATTACH_TIMEOUT     = 3'd0;
   localparam logic [2:0] REG_MAX_ATTACH_RETRIES = 3'd1;
   localparam logic [2:0] REG_DETACH_TIMEOUT     = 3'd2;
   localparam logic [2:0] REG_MAX_DETACH_RETRIES = 3'd3;
   localparam logic [2:0] REG_INACTIVITY_TIMEOUT = 3'd4;
   localparam logic [2:0] REG_HEARTBEAT_INTERVAL = 3'd5;

   localparam logic [31:0] ATTACH_TIMEOUT_RST     = 32'd1000;
   localparam logic [7:0]  MAX_ATTACH_RETRIES_RST = 8'd3;
   localparam logic [31:0] DETACH_TIMEOUT_RST     = 32'd1000;
   localparam logic [7:0]  MAX_DETACH_RETRIES_RST = 8'd3;
   localparam logic [31:0] INACTIVITY_TIMEOUT_RST = 32'd5000;
   localparam logic [31:0] HEARTBEAT_INTERVAL_RST = 32'd1000;
   localparam logic [31:0] SEQUENCE_RST           = 32'd1;

   typedef enum logic [2:0] {
      CMD_BEGIN_ATTACH    = 3'd0,
      CMD_ATTACH_ACCEPTED = 3'd1,
      CMD_BEGIN_DETACH    = 3'd2,
      CMD_DETACH_ACCEPTED = 3'd3,
      CMD_HEARTBEAT_RESP  = 3'd4,
      CMD_TICK            = 3'd5,
      CMD_TAKE_SEQUENCE   = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_ATTACHING = 3'd1,
      ST_ATTACHED  = 3'd2,
      ST_DETACHING = 3'd3,
      ST_RELEASED  = 3'd4,
      ST_REJECTED  = 3'd5
   } state_type;

   typedef enum logic [1:0] {
      MSG_ATTACH    = 2'd0,
      MSG_DETACH    = 2'd1,
      MSG_HEARTBEAT = 2'd2
   } msg_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] now_ms;
      logic [31:0] granted_session;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        send_request;
      msg_type     message_kind;
      logic [31:0] sequence_out;
      state_type   session_state;
      logic [31:0] active_session;
      logic [31:0] previous_session;
      logic        detach_done;
      logic        may_send_data;
   } rsp_type;

   // Per-command decision that the output assembly turns into a result beat.
   typedef struct packed {
      logic        accepted;
      logic        send_request;
      msg_type     message_kind;
      logic [31:0] sequence_out;
   } step_type;

endpackage

`default_nettype wire

// ----- rtl/session_attach_detach_keepalive.sv -----
// Session attach/detach/keepalive controller top level.
// Uses sadk_pkg for command, state and message codes and the beat structs.
//
// Usage:
//   req channel: one command beat (command, now_ms, granted_session) per handshake.
//   rsp channel: exactly one result beat per command, in command order; the status
//   fields show the session after the command has been applied.
//   APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): six timeout and
//   retry registers at byte addresses 0x00..0x14; pready is tied high and reads
//   return the register value. Write registers only while no command is in flight.
// Timing:
//   A command is captured in an input register, evaluated by the state update logic
//   (three 32-bit subtract-compare checks against the stamps) once the output
//   register can advance, and written with its result into the output register.
//   rsp_valid rises once the command has passed the input and output registers;
//   one command per cycle is sustained while rsp_ready stays high. The rate rests
//   on the state update logic, which reads back the state written by the previous
//   command.
// Reset (synchronous, active high) returns the session to idle, the sequence
// counter to one and the configuration registers to their defaults. When rsp_ready is low the
// result stays in the output register, one more command waits in the input
// register, and req_ready drops.
`default_nettype none

module session_attach_detach_keepalive (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  sadk_pkg::req_type              req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output sadk_pkg::rsp_type                    rsp_data,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [sadk_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire  [sadk_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sadk_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   // Configuration registers.
   logic [31:0] attach_timeout_ff;
   logic [7:0]  max_attach_retries_ff;
   logic [31:0] detach_timeout_ff;
   logic [7:0]  max_detach_retries_ff;
   logic [31:0] inactivity_timeout_ff;
   logic [31:0] heartbeat_interval_ff;

   // Session state and its next values.
   sadk_pkg::state_type fsm_ff, fsm_in;
   logic [31:0] cur_sess_ff, cur_sess_in;
   logic [31:0] last_sess_ff, last_sess_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] ctl_tx_ff, ctl_tx_in;
   logic [31:0] hb_ack_ff, hb_ack_in;
   logic [31:0] hb_tx_ff, hb_tx_in;
   logic [7:0]  att_retry_ff, att_retry_in;
   logic [7:0]  det_retry_ff, det_retry_in;
   logic        det_done_ff, det_done_in;

   // Pipeline registers.
   logic              in_valid_ff;
   sadk_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   sadk_pkg::rsp_type out_data_ff;
   sadk_pkg::rsp_type rsp_in;

   sadk_pkg::step_type step;
   logic        advance;
   logic        fire;
   logic        csr_write;
   logic [31:0] now;
   logic [31:0] ctl_elapsed;
   logic [31:0] ack_elapsed;
   logic [31:0] hbtx_elapsed;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   assign now          = in_data_ff.now_ms;
   assign ctl_elapsed  = now - ctl_tx_ff;
   assign ack_elapsed  = now - hb_ack_ff;
   assign hbtx_elapsed = now - hb_tx_ff;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         attach_timeout_ff     <= sadk_pkg::ATTACH_TIMEOUT_RST;
         max_attach_retries_ff <= sadk_pkg::MAX_ATTACH_RETRIES_RST;
         detach_timeout_ff     <= sadk_pkg::DETACH_TIMEOUT_RST;
         max_detach_retries_ff <= sadk_pkg::MAX_DETACH_RETRIES_RST;
         inactivity_timeout_ff <= sadk_pkg::INACTIVITY_TIMEOUT_RST;
         heartbeat_interval_ff <= sadk_pkg::HEARTBEAT_INTERVAL_RST;
      end else if (csr_write) begin
         case (paddr[4:2])
            sadk_pkg::REG_ATTACH_TIMEOUT:     attach_timeout_ff     <= pwdata;
            sadk_pkg::REG_MAX_ATTACH_RETRIES: max_attach_retries_ff <= pwdata[7:0];
            sadk_pkg::REG_DETACH_TIMEOUT:     detach_timeout_ff     <= pwdata;
            sadk_pkg::REG_MAX_DETACH_RETRIES: max_detach_retries_ff <= pwdata[7:0];
            sadk_pkg::REG_INACTIVITY_TIMEOUT: inactivity_timeout_ff <= pwdata;
            sadk_pkg::REG_HEARTBEAT_INTERVAL: heartbeat_interval_ff <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         sadk_pkg::REG_ATTACH_TIMEOUT:     prdata = attach_timeout_ff;
         sadk_pkg::REG_MAX_ATTACH_RETRIES: prdata = {24'd0, max_attach_retries_ff};
         sadk_pkg::REG_DETACH_TIMEOUT:     prdata = detach_timeout_ff;
         sadk_pkg::REG_MAX_DETACH_RETRIES: prdata = {24'd0, max_detach_retries_ff};
         sadk_pkg::REG_INACTIVITY_TIMEOUT: prdata = inactivity_timeout_ff;
         sadk_pkg::REG_HEARTBEAT_INTERVAL: prdata = heartbeat_interval_ff;
         default:                          prdata = '0;
      endcase
   end

   // Next-state logic for the session and the per-command decision.
   always_comb begin
      fsm_in       = fsm_ff;
      cur_sess_in  = cur_sess_ff;
      last_sess_in = last_sess_ff;
      seq_in       = seq_ff;
      ctl_tx_in    = ctl_tx_ff;
      hb_ack_in    = hb_ack_ff;
      hb_tx_in     = hb_tx_ff;
      att_retry_in = att_retry_ff;
      det_retry_in = det_retry_ff;
      det_done_in  = det_done_ff;
      step.accepted     = 1'b0;
      step.send_request = 1'b0;
      step.message_kind = sadk_pkg::MSG_ATTACH;
      step.sequence_out = '0;

      case (in_data_ff.command)
         sadk_pkg::CMD_BEGIN_ATTACH: begin
            if (fsm_ff == sadk_pkg::ST_IDLE || fsm_ff == sadk_pkg::ST_RELEASED ||
                fsm_ff == sadk_pkg::ST_REJECTED) begin
               fsm_in        = sadk_pkg::ST_ATTACHING;
               cur_sess_in   = '0;
               att_retry_in  = '0;
               det_retry_in  = '0;
               det_done_in   = 1'b0;
               ctl_tx_in     = now;
               hb_ack_in     = now;
               hb_tx_in      = now;
               step.accepted = 1'b1;
            end
         end
         sadk_pkg::CMD_ATTACH_ACCEPTED: begin
            if (fsm_ff == sadk_pkg::ST_ATTACHING && in_data_ff.granted_session != '0) begin
               cur_sess_in   = in_data_ff.granted_session;
               last_sess_in  = in_data_ff.granted_session;
               fsm_in        = sadk_pkg::ST_ATTACHED;
               det_done_in   = 1'b0;
               ctl_tx_in     = now;
               hb_ack_in     = now;
               hb_tx_in      = now;
               step.accepted = 1'b1;
            end
         end
         sadk_pkg::CMD_BEGIN_DETACH: begin
            if (fsm_ff == sadk_pkg::ST_ATTACHED) begin
               det_done_in   = 1'b0;
               fsm_in        = sadk_pkg::ST_DETACHING;
               det_retry_in  = '0;
               ctl_tx_in     = now;
               step.accepted = 1'b1;
            end
         end
         sadk_pkg::CMD_DETACH_ACCEPTED: begin
            if (fsm_ff == sadk_pkg::ST_DETACHING) begin
               last_sess_in  = cur_sess_ff;
               cur_sess_in   = '0;
               fsm_in        = sadk_pkg::ST_RELEASED;
               det_done_in   = 1'b1;
               ctl_tx_in     = now;
               hb_ack_in     = now;
               hb_tx_in      = now;
               step.accepted = 1'b1;
            end
         end
         sadk_pkg::CMD_HEARTBEAT_RESP: begin
            // The ack time is recorded in every state.
            hb_ack_in     = now;
            step.accepted = 1'b1;
         end
         sadk_pkg::CMD_TICK: begin
            step.accepted = 1'b1;
            if (fsm_ff == sadk_pkg::ST_ATTACHING && ctl_elapsed >= attach_timeout_ff) begin
               if (att_retry_ff < max_attach_retries_ff) begin
                  att_retry_in      = att_retry_ff + 8'd1;
                  ctl_tx_in         = now;
                  step.send_request = 1'b1;
                  step.message_kind = sadk_pkg::MSG_ATTACH;
               end else begin
                  fsm_in       = sadk_pkg::ST_REJECTED;
                  cur_sess_in  = '0;
                  att_retry_in = '0;
                  det_done_in  = 1'b0;
               end
            end else if (fsm_ff == sadk_pkg::ST_DETACHING &&
                         ctl_elapsed >= detach_timeout_ff) begin
               if (det_retry_ff < max_detach_retries_ff) begin
                  det_retry_in      = det_retry_ff + 8'd1;
                  ctl_tx_in         = now;
                  step.send_request = 1'b1;
                  step.message_kind = sadk_pkg::MSG_DETACH;
               end else begin
                  last_sess_in = cur_sess_ff;
                  cur_sess_in  = '0;
                  fsm_in       = sadk_pkg::ST_RELEASED;
                  det_done_in  = 1'b0;
                  det_retry_in = '0;
               end
            end else if (fsm_ff == sadk_pkg::ST_ATTACHED &&
                         ack_elapsed >= inactivity_timeout_ff) begin
               last_sess_in = cur_sess_ff;
               cur_sess_in  = '0;
               fsm_in       = sadk_pkg::ST_RELEASED;
               det_done_in  = 1'b0;
            end else if (fsm_ff == sadk_pkg::ST_ATTACHED &&
                         hbtx_elapsed >= heartbeat_interval_ff) begin
               hb_tx_in          = now;
               step.send_request = 1'b1;
               step.message_kind = sadk_pkg::MSG_HEARTBEAT;
            end
         end
         sadk_pkg::CMD_TAKE_SEQUENCE: begin
            step.sequence_out = seq_ff;
            seq_in            = seq_ff + 32'd1;
            step.accepted     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result assembly: status fields reflect the session after the update.
   always_comb begin
      rsp_in.accepted         = step.accepted;
      rsp_in.send_request     = step.send_request;
      rsp_in.message_kind     = step.message_kind;
      rsp_in.sequence_out     = step.sequence_out;
      rsp_in.session_state    = fsm_in;
      rsp_in.active_session   = cur_sess_in;
      rsp_in.previous_session = last_sess_in;
      rsp_in.detach_done      = det_done_in;
      rsp_in.may_send_data    = (fsm_in == sadk_pkg::ST_ATTACHED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= sadk_pkg::ST_IDLE;
         cur_sess_ff  <= '0;
         last_sess_ff <= '0;
         seq_ff       <= sadk_pkg::SEQUENCE_RST;
         ctl_tx_ff    <= '0;
         hb_ack_ff    <= '0;
         hb_tx_ff     <= '0;
         att_retry_ff <= '0;
         det_retry_ff <= '0;
         det_done_ff  <= 1'b0;
      end else if (fire) begin
         fsm_ff       <= fsm_in;
         cur_sess_ff  <= cur_sess_in;
         last_sess_ff <= last_sess_in;
         seq_ff       <= seq_in;
         ctl_tx_ff    <= ctl_tx_in;
         hb_ack_ff    <= hb_ack_in;
         hb_tx_ff     <= hb_tx_in;
         att_retry_ff <= att_retry_in;
         det_retry_ff <= det_retry_in;
         det_done_ff  <= det_done_in;
      end
   end

   // Input register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
